FILE: design/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

	localparam int TAG_W  = 32;
	localparam int USE_W  = 32;
	localparam int CNT_W  = 32;
	// line layout: {valid, tag, last_use}
	localparam int LINE_W = 1 + TAG_W + USE_W;

	localparam logic [1:0] ACT_MODIFY = 2'd2;

	localparam logic [1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [1:0] CFG_WAYS       = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOOK,
		ST_REDUCE,
		ST_DONE
	} sac_state_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic rd_en;
		logic look;
		logic reduce;
		logic commit;
	} sac_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic need_reduce;
		logic out_free;
	} sac_stat_t;

endpackage

`default_nettype wire

FILE: design/sac_ram.sv
// ----------------------------------------------------------------------------
// sac_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/sac_ctrl.sv
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer: clearing pass, accept, set read, lookup, LRU reduction, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_ctrl #(
	parameter int LEVELS = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sac_pkg::sac_stat_t stat,
	output sac_pkg::sac_cmd_t      cmd
);

	import sac_pkg::*;

	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	sac_state_t    state_q, state_d;
	logic [LW-1:0] lvl_q;
	logic          lvl_last;

	assign lvl_last = (lvl_q == LW'(LEVELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			lvl_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.look) begin
				lvl_q <= '0;
			end else if (cmd.reduce) begin
				lvl_q <= lvl_q + LW'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (stat.need_reduce && (LEVELS > 0)) begin
					state_d = ST_REDUCE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				if (lvl_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/sac_dpath.sv
// ----------------------------------------------------------------------------
// sac_dpath
// Config registers, address split, set RAM, way compare, LRU tree, counters
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_dpath #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sac_pkg::sac_cmd_t cmd,
	output sac_pkg::sac_stat_t     stat,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [5:0]        cfg_data,
	input  wire logic [1:0]        action,
	input  wire logic [63:0]       address,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   was_hit,
	output logic                   was_miss,
	output logic                   was_evict,
	output logic                   extra_hit,
	output logic [31:0]            hit_total,
	output logic [31:0]            miss_total,
	output logic [31:0]            evict_total
);

	import sac_pkg::*;

	localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int DEPTH  = 1 << MAX_SET_BITS;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LEVELS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
	localparam int NP     = 1 << LEVELS;
	localparam int ROW_W  = MAX_WAYS * LINE_W;

	// configuration
	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] block_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd0;
			ways_q       <= 4'd1;
			block_bits_q <= 6'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				CFG_WAYS:       ways_q       <= cfg_data[3:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// address split
	logic [2:0]          sb_eff;
	logic [3:0]          ways_eff;
	logic [63:0]         addr_sh;
	logic [6:0]          tag_amt;
	logic [SET_AW-1:0]   set_d;
	logic [TAG_W-1:0]    tag_d;
	logic [MAX_WAYS-1:0] en_d;

	always_comb begin
		sb_eff = set_bits_q;
		if ({29'd0, set_bits_q} > MAX_SET_BITS) begin
			sb_eff = 3'(MAX_SET_BITS);
		end
		ways_eff = ways_q;
		if (ways_q == 4'd0) begin
			ways_eff = 4'd1;
		end else if ({28'd0, ways_q} > MAX_WAYS) begin
			ways_eff = 4'(MAX_WAYS);
		end
		addr_sh = address >> block_bits_q;
		for (int i = 0; i < SET_AW; i++) begin
			set_d[i] = addr_sh[i] & (i < {29'd0, sb_eff});
		end
		tag_amt = {1'b0, block_bits_q} + {4'd0, sb_eff};
		tag_d   = (tag_amt >= 7'd64) ? '0 : TAG_W'(address >> tag_amt);
		for (int w = 0; w < MAX_WAYS; w++) begin
			en_d[w] = (w < {28'd0, ways_eff});
		end
	end

	logic [SET_AW-1:0]   set_q;
	logic [TAG_W-1:0]    tag_q;
	logic                modify_q;
	logic [MAX_WAYS-1:0] en_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q    <= set_d;
			tag_q    <= tag_d;
			modify_q <= (action == ACT_MODIFY);
			en_q     <= en_d;
		end
	end

	// clearing pass
	logic [SET_AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + SET_AW'(1);
		end
	end

	// set storage
	logic             ram_we;
	logic [SET_AW-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_wr;

	assign ram_we    = cmd.clear_wr | cmd.commit;
	assign ram_waddr = cmd.clear_wr ? clr_q : set_q;
	assign ram_wdata = cmd.clear_wr ? '0 : row_wr;

	sac_ram #(
		.WIDTH (ROW_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (set_q),
		.rdata (row_rd)
	);

	// lookup
	logic                hit_any, inv_any;
	logic [WAY_W-1:0]    hit_way, inv_way;
	logic [LINE_W-1:0]   line_w;

	always_comb begin
		hit_any = 1'b0;
		inv_any = 1'b0;
		hit_way = '0;
		inv_way = '0;
		line_w  = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			line_w = row_rd[w*LINE_W +: LINE_W];
			if (en_q[w] && line_w[LINE_W-1] && (line_w[USE_W +: TAG_W] == tag_q)) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (en_q[w] && !line_w[LINE_W-1]) begin
				inv_any = 1'b1;
				inv_way = WAY_W'(w);
			end
		end
	end

	logic             hit_q, placed_q;
	logic [WAY_W-1:0] hit_way_q, inv_way_q;

	// LRU reduction tree, one level per cycle; ties keep the lower way
	logic [USE_W-1:0] red_val_q [NP];
	logic [WAY_W-1:0] red_idx_q [NP];
	logic             red_ok_q  [NP];

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_q     <= hit_any;
			hit_way_q <= hit_way;
			placed_q  <= inv_any;
			inv_way_q <= inv_way;
			for (int i = 0; i < NP; i++) begin
				if (i < MAX_WAYS) begin
					red_val_q[i] <= row_rd[i*LINE_W +: USE_W];
					red_idx_q[i] <= WAY_W'(i);
					red_ok_q[i]  <= en_q[i];
				end else begin
					red_val_q[i] <= '0;
					red_idx_q[i] <= '0;
					red_ok_q[i]  <= 1'b0;
				end
			end
		end else if (cmd.reduce) begin
			for (int i = 0; i < NP / 2; i++) begin
				if (!red_ok_q[2*i+1] ||
				    (red_ok_q[2*i] && (red_val_q[2*i] <= red_val_q[2*i+1]))) begin
					red_val_q[i] <= red_val_q[2*i];
					red_idx_q[i] <= red_idx_q[2*i];
					red_ok_q[i]  <= red_ok_q[2*i];
				end else begin
					red_val_q[i] <= red_val_q[2*i+1];
					red_idx_q[i] <= red_idx_q[2*i+1];
					red_ok_q[i]  <= red_ok_q[2*i+1];
				end
			end
		end
	end

	// commit
	logic [CNT_W-1:0] clock_q, hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [CNT_W-1:0] hit_cnt_d, miss_cnt_d, evict_cnt_d;
	logic             evict;
	logic [WAY_W-1:0] way_sel;

	always_comb begin
		evict   = !hit_q && !placed_q;
		way_sel = hit_q ? hit_way_q : (placed_q ? inv_way_q : red_idx_q[0]);
		row_wr  = row_rd;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == way_sel) begin
				if (hit_q) begin
					row_wr[w*LINE_W +: USE_W] = clock_q;
				end else begin
					row_wr[w*LINE_W +: LINE_W] = {1'b1, tag_q, clock_q};
				end
			end
		end
		hit_cnt_d   = hit_cnt_q + CNT_W'(hit_q) + CNT_W'(modify_q);
		miss_cnt_d  = miss_cnt_q + CNT_W'(!hit_q);
		evict_cnt_d = evict_cnt_q + CNT_W'(evict);
	end

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q     <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				clock_q     <= clock_q + CNT_W'(1);
				hit_cnt_q   <= hit_cnt_d;
				miss_cnt_q  <= miss_cnt_d;
				evict_cnt_q <= evict_cnt_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic was_hit_q, was_evict_q, extra_hit_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			was_hit_q   <= hit_q;
			was_evict_q <= evict;
			extra_hit_q <= modify_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign was_hit     = was_hit_q;
	assign was_miss    = !was_hit_q;
	assign was_evict   = was_evict_q;
	assign extra_hit   = extra_hit_q;
	assign hit_total   = hit_cnt_q;
	assign miss_total  = miss_cnt_q;
	assign evict_total = evict_cnt_q;

	assign stat.clear_last  = (clr_q == SET_AW'(DEPTH - 1));
	assign stat.need_reduce = !hit_any && !inv_any;
	assign stat.out_free    = !out_valid_q || !out_stall;

endmodule

`default_nettype wire

FILE: design/set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache model with LRU replacement and running hit, miss
// and eviction totals.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2^MAX_SET_BITS set RAM rows to zero and
// holds in_stall high meanwhile; configuration writes are taken at any time.
// An access then passes READ, LOOK and DONE from acceptance to result when
// it hits or finds a free way, and adds REDUCE states when it evicts, as the
// least-recently-used way is found by a registered tree that resolves one
// level per cycle. One access is in flight at a time, since each reads and
// writes back a whole set row of the single RAM. The result register lets a
// new access be accepted while the previous result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             was_hit,
	output logic             was_miss,
	output logic             was_evict,
	output logic             extra_hit,
	output logic [31:0]      hit_total,
	output logic [31:0]      miss_total,
	output logic [31:0]      evict_total
);

	import sac_pkg::*;

	localparam int LEVELS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;

	sac_cmd_t  cmd;
	sac_stat_t stat;

	assign cfg_ready = 1'b1;

	sac_ctrl #(
		.LEVELS (LEVELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sac_dpath #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.address     (address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.was_hit     (was_hit),
		.was_miss    (was_miss),
		.was_evict   (was_evict),
		.extra_hit   (extra_hit),
		.hit_total   (hit_total),
		.miss_total  (miss_total),
		.evict_total (evict_total)
	);

endmodule

`default_nettype wire

FILE: test/set_assoc_lru_cache_sim_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_tb
// Self-checking bench for the LRU cache model. Accesses are driven under a
// series of cache geometries, from the reset geometry to the register
// extremes. A software copy of the sets predicts each beat's flags and
// totals, and every result beat is checked in order against it. Both sides
// idle in random bursts, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------

module set_assoc_lru_cache_sim_tb;
	import sac_pkg::*;

	localparam int SET_LIMIT   = 6;
	localparam int WAY_LIMIT   = 8;
	localparam int LINES       = (1 << SET_LIMIT) * WAY_LIMIT;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 188;
	localparam int SETTLE      = 16;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_UNDEF  = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic        hit;
		logic        miss;
		logic        evict;
		logic        extra;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evicts;
	} cache_result_t;

	class lru_scoreboard;
		bit            line_ok   [LINES];
		bit [31:0]     line_tag  [LINES];
		bit [31:0]     line_used [LINES];
		bit [31:0]     now_tick;
		bit [31:0]     hits;
		bit [31:0]     misses;
		bit [31:0]     evicts;
		bit [2:0]      set_bits_r;
		bit [3:0]      ways_r = 4'd1;
		bit [5:0]      block_r;
		cache_result_t expected_q[$];
		int            mismatches;
		int            unexpected;
		int            results;

		function void set_reg(logic [1:0] idx, logic [5:0] data);
			case (idx)
			CFG_SET_BITS:   set_bits_r = data[2:0];
			CFG_WAYS:       ways_r = data[3:0];
			CFG_BLOCK_BITS: block_r = data[5:0];
			default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_access(logic [1:0] act, logic [63:0] addr);
			int unsigned   sb;
			int unsigned   nways;
			int unsigned   base;
			int unsigned   victim;
			int unsigned   w;
			logic [63:0]   sh;
			bit [31:0]     tag;
			bit [31:0]     oldest;
			bit            hit;
			cache_result_t r;
			sb = (set_bits_r > SET_LIMIT) ? SET_LIMIT : set_bits_r;
			nways = (ways_r == 0) ? 1 : (ways_r > WAY_LIMIT) ? WAY_LIMIT : ways_r;
			sh = addr >> block_r;
			base = int'(sh & ((64'd1 << sb) - 64'd1)) * WAY_LIMIT;
			sh = addr >> (block_r + sb);
			tag = sh[31:0];
			hit = 1'b0;
			r = '0;
			// lowest matching way wins
			for (w = 0; w < nways && !hit; w++)
				if (line_ok[base + w] && line_tag[base + w] == tag) begin
					hit = 1'b1;
					line_used[base + w] = now_tick;
				end
			if (hit)
				hits++;
			else begin
				misses++;
				victim = nways;
				for (w = 0; w < nways && victim == nways; w++)
					if (!line_ok[base + w])
						victim = w;
				if (victim == nways) begin
					victim = 0;
					oldest = line_used[base];
					for (w = 1; w < nways; w++)
						if (line_used[base + w] < oldest) begin
							oldest = line_used[base + w];
							victim = w;
						end
					r.evict = 1'b1;
					evicts++;
				end
				line_ok[base + victim] = 1'b1;
				line_tag[base + victim] = tag;
				line_used[base + victim] = now_tick;
			end
			r.extra = (act == ACT_MODIFY);
			if (r.extra)
				hits++;
			now_tick++;
			r.hit = hit;
			r.miss = !hit;
			r.hits = hits;
			r.misses = misses;
			r.evicts = evicts;
			expected_q.push_back(r);
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			results++;
			if (expected_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("result beat %0d arrived with nothing outstanding", results);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches + unexpected <= 10) begin
					$display("result beat %0d: expected hit %b miss %b evict %b extra %b totals %0d %0d %0d",
						results, want.hit, want.miss, want.evict, want.extra,
						want.hits, want.misses, want.evicts);
					$display("                 got      hit %b miss %b evict %b extra %b totals %0d %0d %0d",
						got.hit, got.miss, got.evict, got.extra,
						got.hits, got.misses, got.evicts);
				end
			end
		endfunction

		function int failures();
			return mismatches + unexpected + expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [63:0] address;
	logic        out_valid;
	logic        out_stall;
	logic        was_hit;
	logic        was_miss;
	logic        was_evict;
	logic        extra_hit;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] evict_total;

	lru_scoreboard lru_check = new;
	bit            idle_on;
	bit            hold_req;
	int            cycle_count;
	int            settings_used;
	int unsigned   eff_sb;
	int unsigned   eff_ways;
	int unsigned   eff_bb;
	logic [63:0]   recent_addrs[$];

	set_assoc_lru_cache_sim #(
		.MAX_SET_BITS(SET_LIMIT),
		.MAX_WAYS    (WAY_LIMIT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.was_hit    (was_hit),
		.was_miss   (was_miss),
		.was_evict  (was_evict),
		.extra_hit  (extra_hit),
		.hit_total  (hit_total),
		.miss_total (miss_total),
		.evict_total(evict_total)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SET_BITS;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		address = '0;
		out_stall = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, lru_check.pending());
			$display("set_assoc_lru_cache_sim_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin : result_monitor
		cache_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{was_hit, was_miss, was_evict, extra_hit, hit_total, miss_total, evict_total};
			lru_check.check_result(got);
		end
	end

	// output side: random stall bursts, one long hold-off on request
	initial begin : output_side
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_access(input logic [1:0] act, input logic [63:0] addr);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		address <= addr;
		do @(posedge clk); while (in_stall);
		lru_check.note_access(act, addr);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (lru_check.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val, input bit lower);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		lru_check.set_reg(idx, val);
		if (lower)
			cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [5:0] sbits, input logic [5:0] ways,
			input logic [5:0] bbits);
		drain_results();
		write_reg(CFG_SET_BITS, sbits, 1'b0);
		write_reg(CFG_WAYS, ways, 1'b0);
		write_reg(CFG_BLOCK_BITS, bbits, 1'b1);
		eff_sb = (sbits[2:0] > SET_LIMIT) ? SET_LIMIT : sbits[2:0];
		eff_ways = (ways[3:0] == 0) ? 1 : (ways[3:0] > WAY_LIMIT) ? WAY_LIMIT : ways[3:0];
		eff_bb = bbits;
		recent_addrs.delete();
		settings_used++;
	endtask

	// mostly reuse of recent lines and small tag sets, so hits and evictions are common
	function automatic logic [63:0] pick_address();
		logic [63:0] a;
		logic [63:0] offs_mask;
		int unsigned r;
		offs_mask = (64'd1 << eff_bb) - 64'd1;
		r = $urandom_range(0, 99);
		if (r < 55 && recent_addrs.size() > 0)
			a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]
				^ ({$urandom, $urandom} & offs_mask);
		else if (r < 85)
			a = ({32'($urandom), 32'($urandom_range(0, 2 * eff_ways + 1))} << (eff_bb + eff_sb))
				| (64'($urandom_range(0, (1 << eff_sb) - 1)) << eff_bb)
				| ({$urandom, $urandom} & offs_mask);
		else
			a = {$urandom, $urandom};
		recent_addrs.push_back(a);
		if (recent_addrs.size() > 12)
			void'(recent_addrs.pop_front());
		return a;
	endfunction

	initial begin : stimulus
		idle_on = 1'b1;
		hold_req = 1'b0;
		cycle_count = 0;
		settings_used = 1;
		eff_sb = 0;
		eff_ways = 1;
		eff_bb = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: one set, one way
		send_access(ACT_LOAD, 64'd0);
		send_access(ACT_STORE, 64'd0);
		send_access(ACT_MODIFY, 64'd0);
		send_access(ACT_LOAD, 64'd1);
		send_access(ACT_UNDEF, '1);
		send_access(ACT_LOAD, '1);

		set_config(6'd1, 6'd2, 6'd4);
		send_access(ACT_LOAD, 64'h00);
		send_access(ACT_LOAD, 64'h20);
		send_access(ACT_LOAD, 64'h0F);
		send_access(ACT_LOAD, 64'h40);
		send_access(ACT_MODIFY, 64'h10);
		send_access(ACT_STORE, 64'h1F);
		send_access(ACT_LOAD, 64'h8000_0000_0000_0000);

		// shrink then regrow the ways so one tag sits in two of them
		set_config(6'd0, 6'd2, 6'd0);
		send_access(ACT_LOAD, 64'd5);
		send_access(ACT_LOAD, 64'd9);
		set_config(6'd0, 6'd1, 6'd0);
		send_access(ACT_LOAD, 64'd9);
		set_config(6'd0, 6'd2, 6'd0);
		send_access(ACT_LOAD, 64'd9);
		drain_results();
		write_reg(CFG_UNUSED, 6'h2A, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: set_config(6'd2, 6'd4, 6'd4);
			1: set_config(6'd0, 6'd8, 6'd0);
			2: set_config(6'd6, 6'd1, 6'd6);
			3: set_config(6'd63, 6'd0, 6'd32);
			4: set_config(6'd3, 6'd15, 6'd63);
			5: set_config(6'd1, 6'd2, 6'd60);
			default: set_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 12)));
			endcase
			idle_on = (p != PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 40)
					hold_req = 1'b1;
				send_access(2'($urandom_range(0, 3)), pick_address());
			end
		end

		drain_results();
		$display("%0d access beats over %0d cache settings checked", lru_check.results,
			settings_used);
		$display("totals: %0d hits, %0d misses, %0d evictions", lru_check.hits,
			lru_check.misses, lru_check.evicts);
		if (lru_check.failures() == 0)
			$display("set_assoc_lru_cache_sim_tb passed");
		else begin
			$display("%0d mismatches, %0d unexpected beats, %0d missing beats",
				lru_check.mismatches, lru_check.unexpected, lru_check.pending());
			$display("set_assoc_lru_cache_sim_tb failed");
		end
		$finish;
	end

endmodule
